/* design/acjio_pkg.sv */
package acjio_pkg;

	// Bus operation codes
	localparam logic [1:0] OP_CMD_WRITE = 2'd0;
	localparam logic [1:0] OP_CMD_READ  = 2'd1;
	localparam logic [1:0] OP_DATA_READ = 2'd2;
	localparam logic [1:0] OP_NOP       = 2'd3;

	// Command bytes
	localparam logic [7:0] CMD_STOP_PULSE  = 8'h10;
	localparam logic [7:0] CMD_SWITCH_A    = 8'h61;
	localparam logic [7:0] CMD_SWITCH_B    = 8'ha1;
	localparam logic [7:0] CMD_CREDIT      = 8'h91;
	localparam logic [7:0] CMD_READ_INPUTS = 8'h71;

	// Data register offsets
	localparam logic [3:0] OFS_CREDIT   = 4'd0;
	localparam logic [3:0] OFS_JOYSTICK = 4'd1;
	localparam logic [3:0] OFS_CREDIT_LAST = 4'd2;

	localparam logic [7:0] READ_INVALID = 8'hff;
	localparam logic [6:0] CREDIT_MAX   = 7'd99;

	// Bit positions on the active-low ports
	localparam int unsigned CS_COIN1    = 4;
	localparam int unsigned CS_COIN2    = 5;
	localparam int unsigned CS_COIN3    = 6;
	localparam int unsigned CS_START1   = 2;
	localparam int unsigned CS_START2   = 3;
	localparam int unsigned CS_SERVICE  = 7;
	localparam int unsigned JS_UP       = 0;
	localparam int unsigned JS_RIGHT    = 1;
	localparam int unsigned JS_DOWN     = 2;
	localparam int unsigned JS_LEFT     = 3;
	localparam int unsigned JS_FIRE     = 4;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] offset;
		logic [7:0] write_value;
		logic [7:0] coin_start_port;
		logic [7:0] joystick_port;
	} acjio_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       pulse_active;
	} acjio_rsp_t;

endpackage

/* design/acjio_credit.sv */
module acjio_credit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] coin_start_port,
	output logic [7:0] credit_bcd
);
	import acjio_pkg::*;

	logic [6:0]  count_q;
	logic [6:0]  c1, c2, c3, c4, count_next;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [6:0]  tens_x10;
	logic [3:0]  ones;

	// Add coins with saturation, then take credits for the start buttons
	always_comb begin
		c1 = (!coin_start_port[CS_COIN1] && count_q < CREDIT_MAX) ? count_q + 7'd1 : count_q;
		c2 = (!coin_start_port[CS_COIN2] && c1 < CREDIT_MAX) ? c1 + 7'd1 : c1;
		c3 = (!coin_start_port[CS_COIN3] && c2 < CREDIT_MAX) ? c2 + 7'd1 : c2;
		c4 = (!coin_start_port[CS_START1] && c3 >= 7'd1) ? c3 - 7'd1 : c3;
		count_next = (!coin_start_port[CS_START2] && c4 >= 7'd2) ? c4 - 7'd2 : c4;
	end

	// Split into BCD digits: tens by reciprocal multiply, exact for 0..99
	assign tens_prod  = 15'(count_next) * 15'd205;
	assign tens       = tens_prod[14:11];
	assign tens_x10   = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
	assign ones       = 4'(count_next - tens_x10);
	assign credit_bcd = {tens, ones};

	// Hold the count, update on a counting read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_next;
		end
	end

endmodule

/* design/arcade_coin_joystick_io_top.sv */
// Input chip of an arcade board, driven by CPU bus accesses. Each request
// transaction carries one access (command write, command read or data read)
// together with the current coin/start and joystick port levels, and yields
// exactly one response transaction with the read byte and the state of the
// periodic interrupt pulse. One access is taken every clock cycle while
// req_stall is low; a response passes through the input register and then
// the response register. A stalled response blocks new requests only
// once the input register is also occupied.
module arcade_coin_joystick_io_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  acjio_pkg::acjio_req_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output acjio_pkg::acjio_rsp_t rsp
);
	import acjio_pkg::*;

	acjio_req_t req_s1;
	logic       valid_s1;
	acjio_rsp_t rsp_q;
	logic       rsp_valid_q;
	logic [7:0] command_q;
	logic       switch_mode_q;
	logic       pulse_q;

	logic       advance;
	logic       credit_en;
	logic [7:0] credit_bcd;
	logic [3:0] joy_dir;
	logic [7:0] data_byte;
	logic [7:0] read_byte;
	logic       pulse_next;
	logic       up, right, down, left;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Count credits only on a credit read under the input command
	assign credit_en = advance && req_s1.operation == OP_DATA_READ
		&& command_q == CMD_READ_INPUTS && req_s1.offset == OFS_CREDIT;

	acjio_credit u_credit (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (credit_en),
		.coin_start_port (req_s1.coin_start_port),
		.credit_bcd      (credit_bcd)
	);

	// Encode the 8-way joystick; up beats down, right beats left
	always_comb begin
		up    = !req_s1.joystick_port[JS_UP];
		right = !req_s1.joystick_port[JS_RIGHT];
		down  = !req_s1.joystick_port[JS_DOWN];
		left  = !req_s1.joystick_port[JS_LEFT];
		if (up) begin
			joy_dir = right ? 4'd1 : (left ? 4'd7 : 4'd0);
		end else if (down) begin
			joy_dir = right ? 4'd3 : (left ? 4'd5 : 4'd4);
		end else if (right) begin
			joy_dir = 4'd2;
		end else if (left) begin
			joy_dir = 4'd6;
		end else begin
			joy_dir = 4'd8;
		end
	end

	// Select the data read byte
	always_comb begin
		data_byte = READ_INVALID;
		if (command_q == CMD_READ_INPUTS) begin
			if (req_s1.offset == OFS_CREDIT) begin
				data_byte = switch_mode_q
					? (req_s1.coin_start_port & 8'h80) : credit_bcd;
			end else if (req_s1.offset == OFS_JOYSTICK) begin
				data_byte = {3'b000, req_s1.joystick_port[JS_FIRE], joy_dir};
			end
		end else if (command_q == CMD_CREDIT) begin
			if (req_s1.offset <= OFS_CREDIT_LAST) begin
				data_byte = 8'h00;
			end
		end
	end

	// Select the response byte and next pulse state
	always_comb begin
		read_byte  = 8'h00;
		pulse_next = pulse_q;
		case (req_s1.operation)
			OP_CMD_WRITE: pulse_next = (req_s1.write_value != CMD_STOP_PULSE);
			OP_CMD_READ:  read_byte  = command_q;
			OP_DATA_READ: read_byte  = data_byte;
			default:      read_byte  = 8'h00;
		endcase
	end

	// Advance the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// Hold command, mode and pulse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q     <= '0;
			switch_mode_q <= 1'b0;
			pulse_q       <= 1'b0;
		end else if (advance) begin
			pulse_q <= pulse_next;
			if (req_s1.operation == OP_CMD_WRITE) begin
				command_q <= req_s1.write_value;
				if (req_s1.write_value == CMD_SWITCH_A
						|| req_s1.write_value == CMD_SWITCH_B) begin
					switch_mode_q <= 1'b1;
				end else if (req_s1.write_value == CMD_CREDIT) begin
					switch_mode_q <= 1'b0;
				end
			end
		end
	end

	// Load the response register, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.read_data    <= read_byte;
			rsp_q.pulse_active <= pulse_next;
		end
	end

endmodule
